// File: rtl/ise_pkg.sv
// Shared types and sizing constants for the insertion sort engine.
`default_nettype none

package ise_pkg;

   // Number of cells in the sorting chain (legal range 2 to 64)
   localparam int CAPACITY = 32;
   localparam int KEY_W    = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Input word: one key and its end-of-set mark
   typedef struct packed {
      logic signed [KEY_W-1:0] key_value;
      logic                    set_end;
   } req_type;

   // Result word: one sorted key with run and overflow marks
   typedef struct packed {
      logic signed [KEY_W-1:0] sorted_key;
      logic                    run_end;
      logic                    overflowed;
   } rsp_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic shift_out;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/ise_cell.sv
// One cell of the sorting chain: holds a key, takes the new key or its neighbor's.
`default_nettype none

module ise_cell (
   input  wire logic                              clock,
   input  wire ise_pkg::cell_ctrl_type            ctrl,
   input  wire logic signed [ise_pkg::KEY_W-1:0]  new_key,
   input  wire logic                              occupied,
   input  wire logic                              room,
   input  wire logic signed [ise_pkg::KEY_W-1:0]  left_key,
   input  wire logic                              left_move,
   input  wire logic signed [ise_pkg::KEY_W-1:0]  right_key,
   output logic signed [ise_pkg::KEY_W-1:0]       key,
   output logic                                   move
);

   logic signed [ise_pkg::KEY_W-1:0] key_ff;
   logic signed [ise_pkg::KEY_W-1:0] key_in;

   // Cell moves on insert if it is at or past the insertion point:
   // empty slot at the fill edge, or a held key strictly greater
   assign move = room & (~occupied | (key_ff > new_key));

   always_comb begin
      key_in = key_ff;
      priority if (ctrl.insert && move) begin
         // first moving cell takes the new key, the rest shift right
         key_in = left_move ? left_key : new_key;
      end else if (ctrl.shift_out) begin
         key_in = right_key;
      end else begin
         // idle or not at the insertion point: hold
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

`default_nettype wire

// File: rtl/insertion_sort_engine.sv
// Top level of the insertion sort engine: cell chain, fill count and result output.
//
// Usage: present a word on req_word and raise start; the word is taken at a
// rising edge where start is high and busy is low. Each key is placed into a
// chain of CAPACITY cells, after all held keys of equal or lower
// value, so one key per cycle is taken while a set fills.
// The word with set_end high is inserted, then busy rises and the chain
// shifts its keys out toward cell 0, one per cycle. Results appear on
// rsp_word with rsp_valid high for one cycle each, in ascending order; the
// first is read from cell 0 into the result word register once the closing
// word has been taken, and the chain shifts each later key through cell 0.
// run_end marks the largest key. Keys that arrive while all cells are full
// are dropped and every result of that set has overflowed set. busy falls
// with the last result cycle and the next set can start.
// Reset clears the fill count, drop mark, busy flag and output strobe; cell contents
// are only read below the fill count and need no reset.
// The receiver cannot stall: each result must be taken in its cycle.
`default_nettype none

module insertion_sort_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ise_pkg::req_type req_word,
   output logic                  rsp_valid,
   output ise_pkg::rsp_type      rsp_word
);

   localparam int N = ise_pkg::CAPACITY;

   logic [ise_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      drop_ff, drop_in;
   logic                      emit_ff, emit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ise_pkg::rsp_type          rsp_word_ff, rsp_word_in;

   logic                      accept;
   logic                      full;
   ise_pkg::cell_ctrl_type    ctrl;

   logic signed [ise_pkg::KEY_W-1:0] cell_key [N];
   logic                             cell_move [N];

   assign accept = start & ~emit_ff;
   assign full   = (count_ff == ise_pkg::CNT_W'(N));

   // Chain command: insert while filling, shift toward cell 0 while emitting
   assign ctrl.insert    = accept & ~full;
   assign ctrl.shift_out = emit_ff;

   // Cell chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic signed [ise_pkg::KEY_W-1:0] l_key;
      logic signed [ise_pkg::KEY_W-1:0] r_key;
      logic                             l_move;

      if (i == 0) begin : g_first
         assign l_key  = req_word.key_value;
         assign l_move = 1'b0;
      end else begin : g_mid
         assign l_key  = cell_key[i-1];
         assign l_move = cell_move[i-1];
      end

      if (i == N - 1) begin : g_last
         assign r_key = '0;
      end else begin : g_inner
         assign r_key = cell_key[i+1];
      end

      ise_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .new_key   (req_word.key_value),
         .occupied  (count_ff > ise_pkg::CNT_W'(i)),
         .room      (count_ff >= ise_pkg::CNT_W'(i)),
         .left_key  (l_key),
         .left_move (l_move),
         .right_key (r_key),
         .key       (cell_key[i]),
         .move      (cell_move[i])
      );
   end

   // Fill count, drop mark and emission control
   always_comb begin
      count_in     = count_ff;
      drop_in      = drop_ff;
      emit_in      = emit_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in.sorted_key = cell_key[0];
      rsp_word_in.run_end    = (count_ff == ise_pkg::CNT_W'(1));
      rsp_word_in.overflowed = drop_ff;
      priority if (emit_ff) begin
         rsp_valid_in = 1'b1;
         count_in     = count_ff - ise_pkg::CNT_W'(1);
         if (count_ff == ise_pkg::CNT_W'(1)) begin
            emit_in = 1'b0;
            drop_in = 1'b0;
         end
      end else if (accept) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            count_in = count_ff + ise_pkg::CNT_W'(1);
         end
         emit_in = req_word.set_end;
      end else begin
         // idle: hold
         emit_in = emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result word register, payload only
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign busy      = emit_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire
